[design/dcms_pkg.sv]
// Shared types and constants for the depth column minimum scan block.
// Used by all modules under design/; no dependencies of its own.
package dcms_pkg;

  localparam int MAX_WIDTH   = 512;
  localparam int MAX_HEIGHT  = 512;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int ROW_W       = $clog2(MAX_HEIGHT);
  localparam int SIZE_W      = 10;
  localparam int DEPTH_W     = 16;
  localparam int RANGE_W     = 17;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int QUEUE_DEPTH = 3;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ONLY       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NO_RETURN_VALUE   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ZERO_VALUE = 3'd4;

  // reset values
  localparam logic [SIZE_W-1:0]  RST_FRAME_WIDTH       = 10'd320;
  localparam logic [SIZE_W-1:0]  RST_FRAME_HEIGHT      = 10'd240;
  localparam logic [RANGE_W-1:0] RST_NO_RETURN_VALUE   = 17'd99999;
  localparam logic [RANGE_W-1:0] RST_CENTER_ZERO_VALUE = 17'd8;

  typedef struct packed {
    logic [SIZE_W-1:0]  frame_width;
    logic [SIZE_W-1:0]  frame_height;
    logic               center_only;
    logic [RANGE_W-1:0] no_return_value;
    logic [RANGE_W-1:0] center_zero_value;
  } cfg_t;

  typedef struct packed {
    logic [COL_W-1:0]   column;
    logic [RANGE_W-1:0] range_mm;
    logic               last;
  } scan_t;

  // saturate a size register to 1..max
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] max);
    logic [SIZE_W-1:0] res;
    if (v == '0) begin
      res = SIZE_W'(1);
    end else if (v > max) begin
      res = max;
    end else begin
      res = v;
    end
    return res;
  endfunction

endpackage

[design/dcms_cfg.sv]
// Configuration register file for the depth column minimum scan.
// Depends on dcms_pkg.
module dcms_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_valid,
  input  logic [dcms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcms_pkg::CFG_DATA_W-1:0] cfg_data,
  output dcms_pkg::cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.frame_width       <= dcms_pkg::RST_FRAME_WIDTH;
      cfg.frame_height      <= dcms_pkg::RST_FRAME_HEIGHT;
      cfg.center_only       <= 1'b0;
      cfg.no_return_value   <= dcms_pkg::RST_NO_RETURN_VALUE;
      cfg.center_zero_value <= dcms_pkg::RST_CENTER_ZERO_VALUE;
    end else if (cfg_valid) begin
      case (cfg_index)
        dcms_pkg::REG_FRAME_WIDTH: begin
          cfg.frame_width <= cfg_data[dcms_pkg::SIZE_W-1:0];
        end
        dcms_pkg::REG_FRAME_HEIGHT: begin
          cfg.frame_height <= cfg_data[dcms_pkg::SIZE_W-1:0];
        end
        dcms_pkg::REG_CENTER_ONLY: begin
          cfg.center_only <= cfg_data[0];
        end
        dcms_pkg::REG_NO_RETURN_VALUE: begin
          cfg.no_return_value <= cfg_data[dcms_pkg::RANGE_W-1:0];
        end
        dcms_pkg::REG_CENTER_ZERO_VALUE: begin
          cfg.center_zero_value <= cfg_data[dcms_pkg::RANGE_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

endmodule

[design/dcms_ram.sv]
// Column minimum store: one write port, one registered read port.
// Depends on dcms_pkg for depth and width.
module dcms_ram (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [dcms_pkg::COL_W-1:0]   wr_addr,
  input  logic [dcms_pkg::RANGE_W-1:0] wr_data,
  input  logic                         rd_en,
  input  logic [dcms_pkg::COL_W-1:0]   rd_addr,
  output logic [dcms_pkg::RANGE_W-1:0] rd_data
);

  logic [dcms_pkg::RANGE_W-1:0] mem [dcms_pkg::MAX_WIDTH];

  // read returns the old entry when both ports hit the same address
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[design/dcms_queue.sv]
// Small result queue between the update stage and the scan output port.
// Depends on dcms_pkg.
module dcms_queue (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        push,
  input  dcms_pkg::scan_t             push_data,
  input  logic                        pop_stall,
  output logic                        pop_valid,
  output dcms_pkg::scan_t             pop_data,
  output logic [dcms_pkg::QCNT_W-1:0] count
);

  dcms_pkg::scan_t entries [dcms_pkg::QUEUE_DEPTH];
  logic [dcms_pkg::QPTR_W-1:0] wr_ptr;
  logic [dcms_pkg::QPTR_W-1:0] rd_ptr;
  logic pop;

  assign pop_valid = (count != '0);
  assign pop_data  = entries[rd_ptr];
  assign pop       = pop_valid && !pop_stall;

  function automatic logic [dcms_pkg::QPTR_W-1:0] ptr_inc(
      input logic [dcms_pkg::QPTR_W-1:0] p);
    logic [dcms_pkg::QPTR_W-1:0] res;
    if (p == dcms_pkg::QPTR_W'(dcms_pkg::QUEUE_DEPTH - 1)) begin
      res = '0;
    end else begin
      res = p + 1'b1;
    end
    return res;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule

[design/depth_column_min_scan.sv]
// Depth column minimum scan: per-column running minimum of non-zero depth
// pixels, one scan value per pixel of the last row; in center mode, the
// middle row's own depth instead (zero gives the center zero value). One
// pixel per cycle while the input is not stalled; a scan value follows its
// pixel through the column store read and the update stage.
// Synchronous reset clears counters, pipeline and queue and loads config
// defaults; the column store is not cleared, row 0 of each frame seeds it.
module depth_column_min_scan (
  input  logic                            clk,
  input  logic                            rst,
  // depth pixel input
  input  logic                            depth_valid,
  output logic                            depth_stall,
  input  logic [dcms_pkg::DEPTH_W-1:0]    depth_mm,
  // scan output
  output logic                            scan_valid,
  input  logic                            scan_stall,
  output logic [dcms_pkg::COL_W-1:0]      column,
  output logic [dcms_pkg::RANGE_W-1:0]    range_mm,
  output logic                            last,
  // config write
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [dcms_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dcms_pkg::CFG_DATA_W-1:0] cfg_data
);

  dcms_pkg::cfg_t cfg;

  assign cfg_ready = 1'b1;

  dcms_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // ---------------------------------------------------------------------
  // Stage 0: raster position and store read
  // ---------------------------------------------------------------------
  logic [dcms_pkg::SIZE_W-1:0] eff_w;
  logic [dcms_pkg::SIZE_W-1:0] eff_h;
  logic [dcms_pkg::COL_W-1:0]  col_count;
  logic [dcms_pkg::ROW_W-1:0]  row_count;
  logic [dcms_pkg::COL_W-1:0]  col_cur;
  logic [dcms_pkg::ROW_W-1:0]  row_cur;
  logic [dcms_pkg::SIZE_W-1:0] col_inc;
  logic [dcms_pkg::SIZE_W-1:0] row_inc;
  logic                        accept;
  logic [dcms_pkg::QCNT_W-1:0] queue_count;

  assign eff_w = dcms_pkg::clamp_size(cfg.frame_width,
                                      dcms_pkg::SIZE_W'(dcms_pkg::MAX_WIDTH));
  assign eff_h = dcms_pkg::clamp_size(cfg.frame_height,
                                      dcms_pkg::SIZE_W'(dcms_pkg::MAX_HEIGHT));

  // counters left past the frame size by a config change wrap first
  assign col_cur = ({1'b0, col_count} >= eff_w) ? '0 : col_count;
  assign row_cur = ({1'b0, row_count} >= eff_h) ? '0 : row_count;
  assign col_inc = {1'b0, col_cur} + 1'b1;
  assign row_inc = {1'b0, row_cur} + 1'b1;

  // Queue credit: everything in flight (update stage plus queue) must fit
  // in the queue, so the update stage never has to hold.
  logic s1_valid;
  assign depth_stall = ({1'b0, queue_count} + {{dcms_pkg::QCNT_W{1'b0}}, s1_valid})
                       >= (dcms_pkg::QCNT_W + 1)'(dcms_pkg::QUEUE_DEPTH);
  assign accept = depth_valid && !depth_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_count <= '0;
      row_count <= '0;
    end else if (accept) begin
      if (col_inc >= eff_w) begin
        col_count <= '0;
        row_count <= (row_inc >= eff_h) ? '0 : row_inc[dcms_pkg::ROW_W-1:0];
      end else begin
        col_count <= col_inc[dcms_pkg::COL_W-1:0];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stage 1: min update and write back
  // ---------------------------------------------------------------------
  logic [dcms_pkg::COL_W-1:0]   s1_col;
  logic [dcms_pkg::DEPTH_W-1:0] s1_depth;
  logic                         s1_row0;
  logic                         s1_emit;
  logic                         s1_center;
  logic                         s1_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col    <= col_cur;
      s1_depth  <= depth_mm;
      s1_row0   <= (row_cur == '0);
      s1_center <= cfg.center_only;
      s1_last   <= ({1'b0, col_cur} == eff_w - 1'b1);
      if (cfg.center_only) begin
        s1_emit <= ({1'b0, row_cur} == (eff_h >> 1));
      end else begin
        s1_emit <= ({1'b0, row_cur} == eff_h - 1'b1);
      end
    end
  end

  logic [dcms_pkg::RANGE_W-1:0] rd_data;
  logic [dcms_pkg::RANGE_W-1:0] min_base;
  logic [dcms_pkg::RANGE_W-1:0] min_new;
  logic [dcms_pkg::RANGE_W-1:0] depth_ext;

  // Forwarding: a write in the same cycle as the read is missed by the
  // store (only possible at width one), so catch it here.
  logic                         fwd_valid;
  logic [dcms_pkg::COL_W-1:0]   fwd_col;
  logic [dcms_pkg::RANGE_W-1:0] fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    fwd_col  <= s1_col;
    fwd_data <= min_new;
  end

  dcms_ram u_ram (
    .clk     (clk),
    .wr_en   (s1_valid),
    .wr_addr (s1_col),
    .wr_data (min_new),
    .rd_en   (accept),
    .rd_addr (col_cur),
    .rd_data (rd_data)
  );

  assign depth_ext = {1'b0, s1_depth};

  always_comb begin
    if (s1_row0) begin
      min_base = cfg.no_return_value;
    end else if (fwd_valid && (fwd_col == s1_col)) begin
      min_base = fwd_data;
    end else begin
      min_base = rd_data;
    end
    if ((s1_depth != '0) && (depth_ext < min_base)) begin
      min_new = depth_ext;
    end else begin
      min_new = min_base;
    end
  end

  // ---------------------------------------------------------------------
  // Result queue and output port
  // ---------------------------------------------------------------------
  dcms_pkg::scan_t push_data;
  dcms_pkg::scan_t pop_data;

  always_comb begin
    push_data.column = s1_col;
    push_data.last   = s1_last;
    if (s1_center) begin
      push_data.range_mm = (s1_depth != '0) ? depth_ext : cfg.center_zero_value;
    end else begin
      push_data.range_mm = min_new;
    end
  end

  dcms_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s1_valid && s1_emit),
    .push_data (push_data),
    .pop_stall (scan_stall),
    .pop_valid (scan_valid),
    .pop_data  (pop_data),
    .count     (queue_count)
  );

  assign column   = pop_data.column;
  assign range_mm = pop_data.range_mm;
  assign last     = pop_data.last;

endmodule

[design/dcms_check.sv]
// Port-level checks for the depth column minimum scan, bound to the top.
// Depends on dcms_pkg and depth_column_min_scan.
module dcms_check (
  input logic                         clk,
  input logic                         rst,
  input logic                         depth_stall,
  input logic                         scan_valid,
  input logic                         scan_stall,
  input logic [dcms_pkg::COL_W-1:0]   column,
  input logic [dcms_pkg::RANGE_W-1:0] range_mm,
  input logic                         last
);

  // reset empties the pipeline and opens the input
  a_reset_clear: assert property (@(posedge clk)
    rst |=> (!scan_valid && !depth_stall))
    else $error("scan output or input stall active after reset");

  // input only stalls while results are backed up at the output
  a_stall_backed_up: assert property (@(posedge clk) disable iff (rst)
    depth_stall |-> scan_valid)
    else $error("input stalled with no pending scan transfer");

  a_scan_hold_valid: assert property (@(posedge clk) disable iff (rst)
    (scan_valid && scan_stall) |=> scan_valid)
    else $error("scan valid dropped while stalled");

  a_scan_hold_data: assert property (@(posedge clk) disable iff (rst)
    (scan_valid && scan_stall) |=>
      ($stable(column) && $stable(range_mm) && $stable(last)))
    else $error("scan payload changed while stalled");

endmodule

bind depth_column_min_scan dcms_check u_dcms_check (.*);
